[rtl/core/rjf_pkg.sv]
// Package for the RTCM / JSON stream framer: mode and event codes,
// protocol byte constants and the per-byte result record.
// No dependencies.
`timescale 1ns / 1ps

package rjf_pkg;

    localparam logic [7:0] SYNC_BYTE   = 8'hD3;
    localparam logic [7:0] OPEN_BRACE  = 8'h7B;
    localparam logic [7:0] CLOSE_BRACE = 8'h7D;

    localparam int unsigned RTCM_OVERHEAD = 6;
    localparam int unsigned LEN_HIGH_POS  = 2;
    localparam int unsigned LEN_LOW_POS   = 3;

    // Width of a frame position wide enough for any buffer size in range
    localparam int unsigned POS_W        = 17;
    localparam int unsigned PAYLOAD_W    = 16;
    localparam int unsigned FRAME_BYTES_W = 11;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RTCM = 2'd1,
        MODE_JSON = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        EV_DROP         = 3'd0,
        EV_RTCM         = 3'd1,
        EV_RTCM_END     = 3'd2,
        EV_RTCM_LONG    = 3'd3,
        EV_RTCM_OVERRUN = 3'd4,
        EV_JSON         = 3'd5,
        EV_JSON_END     = 3'd6,
        EV_OVERFLOW     = 3'd7
    } event_t;

    typedef struct packed {
        logic [7:0]               byte_out;
        logic                     forward_gnss;
        logic                     json_member;
        logic                     frame_start;
        event_t                   event_res;
        logic                     frame_last;
        logic [FRAME_BYTES_W-1:0] frame_bytes;
    } result_t;

endpackage

[rtl/core/rjf_step.sv]
// Framing state and the combinational decision for one received byte.
// Depends on rjf_pkg.
`timescale 1ns / 1ps

module rjf_step #(
    parameter int unsigned BUFFER_BYTES = 1024,
    parameter int unsigned MAX_PAYLOAD  = 1023
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [7:0]        rx_byte,
    output rjf_pkg::result_t  result
);

    localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);

    rjf_pkg::mode_t                    mode_reg, mode_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [rjf_pkg::PAYLOAD_W-1:0]     payload_len_reg, payload_len_next;
    logic [7:0]                        len_high_reg, len_high_next;
    logic [7:0]                        open_reg, open_next;
    logic [7:0]                        close_reg, close_next;

    logic [CNT_W-1:0]                  count_inc;
    logic [rjf_pkg::POS_W-1:0]         pos;
    logic [rjf_pkg::POS_W-1:0]         end_pos;
    logic [rjf_pkg::PAYLOAD_W-1:0]     length_val;
    logic                              closed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= rjf_pkg::MODE_IDLE;
            count_reg       <= '0;
            payload_len_reg <= '0;
            len_high_reg    <= '0;
            open_reg        <= '0;
            close_reg       <= '0;
        end
        else if (step_en)
        begin
            mode_reg        <= mode_next;
            count_reg       <= count_next;
            payload_len_reg <= payload_len_next;
            len_high_reg    <= len_high_next;
            open_reg        <= open_next;
            close_reg       <= close_next;
        end
    end

    always_comb
    begin
        mode_next        = mode_reg;
        count_next       = count_reg;
        payload_len_next = payload_len_reg;
        len_high_next    = len_high_reg;
        open_next        = open_reg;
        close_next       = close_reg;
        closed           = 1'b0;

        count_inc  = count_reg + CNT_W'(1);
        pos        = rjf_pkg::POS_W'(count_inc);
        end_pos    = rjf_pkg::POS_W'(payload_len_reg)
                   + rjf_pkg::POS_W'(rjf_pkg::RTCM_OVERHEAD);
        length_val = {len_high_reg, rx_byte};

        result.byte_out     = rx_byte;
        result.forward_gnss = 1'b0;
        result.json_member  = 1'b0;
        result.frame_start  = 1'b0;
        result.event_res    = rjf_pkg::EV_DROP;
        result.frame_last   = 1'b0;
        result.frame_bytes  = pos[rjf_pkg::FRAME_BYTES_W-1:0];

        case (mode_reg)
            rjf_pkg::MODE_RTCM:
            begin
                count_next          = count_inc;
                result.forward_gnss = 1'b1;
                result.event_res    = rjf_pkg::EV_RTCM;
                if (pos == rjf_pkg::POS_W'(rjf_pkg::LEN_HIGH_POS))
                begin
                    len_high_next = rx_byte;
                end
                if (pos == rjf_pkg::POS_W'(rjf_pkg::LEN_LOW_POS))
                begin
                    payload_len_next = length_val;
                    if (length_val > rjf_pkg::PAYLOAD_W'(MAX_PAYLOAD))
                    begin
                        result.event_res = rjf_pkg::EV_RTCM_LONG;
                        payload_len_next = '0;
                        closed           = 1'b1;
                    end
                end
                else if (pos == end_pos)
                begin
                    result.event_res = rjf_pkg::EV_RTCM_END;
                    payload_len_next = '0;
                    closed           = 1'b1;
                end
                else if (pos > end_pos)
                begin
                    result.event_res = rjf_pkg::EV_RTCM_OVERRUN;
                    payload_len_next = '0;
                    closed           = 1'b1;
                end
            end
            rjf_pkg::MODE_JSON:
            begin
                count_next         = count_inc;
                result.json_member = 1'b1;
                result.event_res   = rjf_pkg::EV_JSON;
                if (rx_byte == rjf_pkg::OPEN_BRACE)
                begin
                    open_next = open_reg + 8'd1;
                end
                else if (rx_byte == rjf_pkg::CLOSE_BRACE)
                begin
                    close_next = close_reg + 8'd1;
                end
                if (open_next == close_next)
                begin
                    result.event_res = rjf_pkg::EV_JSON_END;
                    closed           = 1'b1;
                end
            end
            default:
            begin
                result.frame_bytes = '0;
                if (rx_byte == rjf_pkg::SYNC_BYTE)
                begin
                    mode_next           = rjf_pkg::MODE_RTCM;
                    count_next          = CNT_W'(1);
                    result.forward_gnss = 1'b1;
                    result.frame_start  = 1'b1;
                    result.event_res    = rjf_pkg::EV_RTCM;
                    result.frame_bytes  = rjf_pkg::FRAME_BYTES_W'(1);
                end
                else if (rx_byte == rjf_pkg::OPEN_BRACE)
                begin
                    mode_next          = rjf_pkg::MODE_JSON;
                    count_next         = CNT_W'(1);
                    open_next          = 8'd1;
                    close_next         = 8'd0;
                    result.json_member = 1'b1;
                    result.frame_start = 1'b1;
                    result.event_res   = rjf_pkg::EV_JSON;
                    result.frame_bytes = rjf_pkg::FRAME_BYTES_W'(1);
                end
                else
                begin
                    mode_next  = rjf_pkg::MODE_IDLE;
                    count_next = '0;
                end
            end
        endcase

        // drop an open frame that fills the buffer
        if ((mode_reg == rjf_pkg::MODE_RTCM || mode_reg == rjf_pkg::MODE_JSON) && !closed
            && pos >= rjf_pkg::POS_W'(BUFFER_BYTES))
        begin
            result.event_res = rjf_pkg::EV_OVERFLOW;
            closed           = 1'b1;
        end

        if (closed)
        begin
            result.frame_last = 1'b1;
            mode_next         = rjf_pkg::MODE_IDLE;
            count_next        = '0;
        end
    end

endmodule

[rtl/core/rjf_out_reg.sv]
// Result register between the framing logic and the output stream.
// Depends on rjf_pkg.
`timescale 1ns / 1ps

module rjf_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  rjf_pkg::result_t  result,
    input  logic              out_ready,
    output logic              can_load,
    output logic              out_valid,
    output rjf_pkg::result_t  out_result
);

    logic              valid_reg, valid_next;
    rjf_pkg::result_t  data_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_result = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

endmodule

[rtl/core/rtcm_json_stream_framer.sv]
// Top level of the RTCM / JSON stream framer: input register, framing step
// and result register. Depends on rjf_pkg, rjf_step and rjf_out_reg.
`timescale 1ns / 1ps

// Sorts a received byte stream into RTCM frames (opened by 0xD3, length from
// bytes 1 and 2, ended after six bytes plus the payload length) and JSON
// frames (opened by '{', ended when the brace counts match). Every byte comes
// out as one transaction with its routing flags, an event code and the frame
// byte count; tlast marks the byte that ends or discards a frame. One byte is
// taken every clock cycle while the output accepts results. A taken byte is
// held in the input register for the combinational framing step, whose result
// is loaded into the result register that drives the output. Frames that
// reach BUFFER_BYTES bytes without ending there are discarded, as are RTCM
// frames whose length exceeds MAX_PAYLOAD.

module rtcm_json_stream_framer #(
    parameter int unsigned BUFFER_BYTES = 1024,
    parameter int unsigned MAX_PAYLOAD  = 1023
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] byte_out, [18:8] frame_bytes, [23:19] zero
    output logic [5:0]  m_tuser,   // [0] forward_gnss, [1] json_member, [2] frame_start,
                                   // [5:3] event_res
    output logic        m_tlast    // frame_last
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              advance;
    logic              out_can_load;
    rjf_pkg::result_t  step_result;
    rjf_pkg::result_t  out_result;

    assign advance       = in_valid_reg && out_can_load;
    assign s_tready      = !in_valid_reg || advance;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    rjf_step #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_PAYLOAD  (MAX_PAYLOAD)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .rx_byte (in_byte_reg),
        .result  (step_result)
    );

    rjf_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result     (step_result),
        .out_ready  (m_tready),
        .can_load   (out_can_load),
        .out_valid  (m_tvalid),
        .out_result (out_result)
    );

    assign m_tdata = {5'd0, out_result.frame_bytes, out_result.byte_out};
    assign m_tuser = {out_result.event_res, out_result.frame_start,
                      out_result.json_member, out_result.forward_gnss};
    assign m_tlast = out_result.frame_last;

endmodule

[bench/rtcm_json_stream_framer_tb.sv]
// Self-checking testbench for rtcm_json_stream_framer: byte stream in, one result
// transaction per byte out, compared with an in-bench framing predictor.
// Depends on rjf_pkg and rtcm_json_stream_framer.
`timescale 1ns / 1ps

module rtcm_json_stream_framer_tb;

    localparam int unsigned BUFFER_BYTES = 1024;
    localparam int unsigned MAX_PAYLOAD  = 1023;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned STALL_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [5:0]  m_tuser;
    logic        m_tlast;

    // framer state as predicted
    rjf_pkg::mode_t fr_mode = rjf_pkg::MODE_IDLE;
    logic [16:0]   fr_count = '0;
    logic [15:0]   fr_payload_len = '0;
    logic [7:0]    fr_len_high = '0;
    logic [7:0]    fr_opens = '0;
    logic [7:0]    fr_closes = '0;

    rjf_pkg::result_t pending_results[$];
    rjf_pkg::result_t oldest;
    int unsigned   mismatches = 0;
    int unsigned   bytes_offered = 0;
    int unsigned   cycle_count = 0;
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_idle_pct = 0;
    logic          hold_req = 1'b0;
    int unsigned   stall_left = 0;

    rtcm_json_stream_framer #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic rjf_pkg::result_t advance_framer(input logic [7:0] b);
        rjf_pkg::result_t r;
        logic [16:0]      end_pos;
        r = '0;
        r.byte_out = b;
        r.event_res = rjf_pkg::EV_DROP;
        if (fr_mode != rjf_pkg::MODE_RTCM && fr_mode != rjf_pkg::MODE_JSON)
        begin
            if (b == rjf_pkg::SYNC_BYTE)
            begin
                fr_mode = rjf_pkg::MODE_RTCM;
                fr_count = 17'd1;
                r.forward_gnss = 1'b1;
                r.frame_start = 1'b1;
                r.event_res = rjf_pkg::EV_RTCM;
                r.frame_bytes = 11'd1;
            end
            else if (b == rjf_pkg::OPEN_BRACE)
            begin
                fr_mode = rjf_pkg::MODE_JSON;
                fr_count = 17'd1;
                fr_opens = 8'd1;
                fr_closes = 8'd0;
                r.json_member = 1'b1;
                r.frame_start = 1'b1;
                r.event_res = rjf_pkg::EV_JSON;
                r.frame_bytes = 11'd1;
            end
            else
            begin
                fr_mode = rjf_pkg::MODE_IDLE;
                fr_count = '0;
            end
            return r;
        end
        fr_count = fr_count + 17'd1;
        r.frame_bytes = fr_count[10:0];
        r.forward_gnss = (fr_mode == rjf_pkg::MODE_RTCM);
        r.json_member = (fr_mode == rjf_pkg::MODE_JSON);
        if (fr_mode == rjf_pkg::MODE_RTCM)
        begin
            end_pos = {1'b0, fr_payload_len} + 17'(rjf_pkg::RTCM_OVERHEAD);
            r.event_res = rjf_pkg::EV_RTCM;
            if (fr_count == rjf_pkg::LEN_HIGH_POS)
                fr_len_high = b;
            if (fr_count == rjf_pkg::LEN_LOW_POS)
            begin
                fr_payload_len = {fr_len_high, b};
                if (fr_payload_len > MAX_PAYLOAD)
                begin
                    r.event_res = rjf_pkg::EV_RTCM_LONG;
                    r.frame_last = 1'b1;
                    fr_payload_len = '0;
                    fr_mode = rjf_pkg::MODE_IDLE;
                    fr_count = '0;
                end
            end
            else if (fr_count == end_pos)
            begin
                r.event_res = rjf_pkg::EV_RTCM_END;
                r.frame_last = 1'b1;
                fr_payload_len = '0;
                fr_mode = rjf_pkg::MODE_IDLE;
                fr_count = '0;
            end
            else if (fr_count > end_pos)
            begin
                r.event_res = rjf_pkg::EV_RTCM_OVERRUN;
                r.frame_last = 1'b1;
                fr_payload_len = '0;
                fr_mode = rjf_pkg::MODE_IDLE;
                fr_count = '0;
            end
        end
        else
        begin
            r.event_res = rjf_pkg::EV_JSON;
            if (b == rjf_pkg::OPEN_BRACE)
                fr_opens = fr_opens + 8'd1;
            else if (b == rjf_pkg::CLOSE_BRACE)
                fr_closes = fr_closes + 8'd1;
            if (fr_opens == fr_closes)
            begin
                r.event_res = rjf_pkg::EV_JSON_END;
                r.frame_last = 1'b1;
                fr_mode = rjf_pkg::MODE_IDLE;
                fr_count = '0;
            end
        end
        if (fr_count >= BUFFER_BYTES)
        begin
            r.event_res = rjf_pkg::EV_OVERFLOW;
            r.frame_last = 1'b1;
            fr_mode = rjf_pkg::MODE_IDLE;
            fr_count = '0;
        end
        return r;
    endfunction

    // offer one byte, hold it until taken, then record its predicted result
    task automatic offer_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(advance_framer(b));
        bytes_offered++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic offer_frame(input logic [7:0] bytes[$]);
        foreach (bytes[i])
            offer_byte(bytes[i]);
    endtask

    task automatic offer_random_frame();
        int unsigned kind;
        int unsigned len;
        int unsigned pick;
        int          depth;
        int unsigned n;
        logic [7:0]  b;
        kind = $urandom_range(99);
        if (kind < 40)
        begin
            offer_byte(rjf_pkg::SYNC_BYTE);
            if ($urandom_range(9) == 0)
                len = $urandom_range(16'hFFFF);
            else
                len = $urandom_range(24);
            offer_byte(len[15:8]);
            offer_byte(len[7:0]);
            if (len <= MAX_PAYLOAD)
                repeat (len + 3) offer_byte(8'($urandom_range(255)));
        end
        else if (kind < 82)
        begin
            offer_byte(rjf_pkg::OPEN_BRACE);
            depth = 1;
            n = 0;
            while (depth != 0 && n < 48)
            begin
                pick = $urandom_range(99);
                if (pick < 20)
                    b = rjf_pkg::OPEN_BRACE;
                else if (pick < 45)
                    b = rjf_pkg::CLOSE_BRACE;
                else
                    b = 8'($urandom_range(255));
                if (b == rjf_pkg::OPEN_BRACE)
                    depth++;
                else if (b == rjf_pkg::CLOSE_BRACE)
                    depth--;
                offer_byte(b);
                n++;
            end
        end
        else
        begin
            repeat ($urandom_range(1, 4)) offer_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic test_idle_bytes();
        offer_frame('{8'h00, 8'hFF, rjf_pkg::CLOSE_BRACE, 8'h55, 8'hAA});
        drain();
    endtask

    task automatic test_rtcm_frames();
        offer_frame('{rjf_pkg::SYNC_BYTE, 8'h00, 8'h00, 8'h11, 8'h22, 8'h33});
        offer_frame('{rjf_pkg::SYNC_BYTE, 8'h00, 8'h02, rjf_pkg::OPEN_BRACE,
                      rjf_pkg::SYNC_BYTE, 8'hC0, 8'h0C, 8'hFF});
        drain();
    endtask

    task automatic test_rtcm_length_limit();
        offer_frame('{rjf_pkg::SYNC_BYTE, 8'h04, 8'h00});
        offer_frame('{rjf_pkg::SYNC_BYTE, 8'hFF, 8'hFF});
        drain();
    endtask

    task automatic test_json_frames();
        offer_frame('{rjf_pkg::OPEN_BRACE, rjf_pkg::CLOSE_BRACE});
        offer_frame('{rjf_pkg::OPEN_BRACE, rjf_pkg::OPEN_BRACE, 8'h61, rjf_pkg::CLOSE_BRACE,
                      rjf_pkg::SYNC_BYTE, rjf_pkg::CLOSE_BRACE});
        drain();
    endtask

    task automatic test_long_frames();
        logic [15:0] lens[$];
        lens = '{16'd1023, 16'd1019, 16'd1018, 16'd1017};
        offer_byte(rjf_pkg::OPEN_BRACE);
        repeat (BUFFER_BYTES - 1) offer_byte(8'h20);
        foreach (lens[i])
        begin
            offer_frame('{rjf_pkg::SYNC_BYTE, lens[i][15:8], lens[i][7:0]});
            repeat (lens[i] + 3) offer_byte(8'($urandom_range(255)));
        end
        // brace count wraps back to equal after 256 opens
        repeat (256) offer_byte(rjf_pkg::OPEN_BRACE);
        offer_frame('{rjf_pkg::SYNC_BYTE, 8'h00, 8'h01, 8'h5A, 8'h01, 8'h02, 8'h03});
        drain();
    endtask

    task automatic test_output_stall();
        int unsigned start;
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        start = bytes_offered;
        while (bytes_offered - start < 80)
            offer_random_frame();
        drain();
    endtask

    task automatic test_random_stream(input int unsigned count);
        int unsigned start;
        start = bytes_offered;
        while (bytes_offered - start < count)
            offer_random_frame();
        drain();
    endtask

    always @(posedge clk)
    begin
        if (hold_req)
            stall_left <= STALL_CYCLES;
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        m_tready <= !hold_req && stall_left == 0 && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction: byte_out %h", m_tdata[7:0]);
                mismatches++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (m_tdata[7:0] !== oldest.byte_out)
                begin
                    $error("byte_out: expected %h, got %h", oldest.byte_out, m_tdata[7:0]);
                    mismatches++;
                end
                if (m_tuser[0] !== oldest.forward_gnss)
                begin
                    $error("forward_gnss: expected %b, got %b", oldest.forward_gnss, m_tuser[0]);
                    mismatches++;
                end
                if (m_tuser[1] !== oldest.json_member)
                begin
                    $error("json_member: expected %b, got %b", oldest.json_member, m_tuser[1]);
                    mismatches++;
                end
                if (m_tuser[2] !== oldest.frame_start)
                begin
                    $error("frame_start: expected %b, got %b", oldest.frame_start, m_tuser[2]);
                    mismatches++;
                end
                if (m_tuser[5:3] !== oldest.event_res)
                begin
                    $error("event_res: expected %0d, got %0d", oldest.event_res, m_tuser[5:3]);
                    mismatches++;
                end
                if (m_tlast !== oldest.frame_last)
                begin
                    $error("frame_last: expected %b, got %b", oldest.frame_last, m_tlast);
                    mismatches++;
                end
                if (m_tdata[18:8] !== oldest.frame_bytes)
                begin
                    $error("frame_bytes: expected %0d, got %0d", oldest.frame_bytes,
                           m_tdata[18:8]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 36;
        recv_idle_pct = 82;
        test_idle_bytes();
        test_rtcm_frames();
        test_rtcm_length_limit();
        test_json_frames();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_long_frames();
        test_output_stall();

        send_idle_pct = 36;
        recv_idle_pct = 82;
        test_random_stream(300);
        send_idle_pct = 82;
        recv_idle_pct = 36;
        test_random_stream(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(300);

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[rtcm_json_stream_framer.f]
rtl/core/rjf_pkg.sv
rtl/core/rjf_step.sv
rtl/core/rjf_out_reg.sv
rtl/core/rtcm_json_stream_framer.sv
bench/rtcm_json_stream_framer_tb.sv
